@@ hw/rtl/md5_four_lane_hash_macros.svh @@
// assertion helpers
`ifndef MD5_FOUR_LANE_HASH_MACROS_SVH
`define MD5_FOUR_LANE_HASH_MACROS_SVH
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 check failed");
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 check failed");
`endif

@@ hw/rtl/md5_pkg.sv @@
package md5_pkg;
   localparam int unsigned IN_LANES = 4;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_EMIT
   } state_type;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   typedef struct packed {
      logic       start;
      logic       step;
      logic       fold;
      logic       restart;
      logic [5:0] idx;
   } ctrl_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } abcd_type;

   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [3:0] word_index(input logic [5:0] i);
      logic [3:0] g;
      unique case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
         2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
         default: g = 4'(i[3:0] * 4'd7);
      endcase
      return g;
   endfunction

   function automatic logic [31:0] bswap(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction
endpackage

@@ hw/rtl/md5_lane.sv @@
module md5_lane (
   input  logic               clock,
   input  md5_pkg::ctrl_type  ctrl,
   input  logic [31:0]        word,
   input  md5_pkg::abcd_type  chain,
   output md5_pkg::abcd_type  sum
);
   md5_pkg::abcd_type work_ff, work_in;
   logic [31:0] f, t, rot, kk;
   logic [4:0]  s;

   always_comb begin
      unique case (ctrl.idx[5:4])
         2'd0: f = (work_ff.b & work_ff.c) | (~work_ff.b & work_ff.d);
         2'd1: f = (work_ff.b & work_ff.d) | (work_ff.c & ~work_ff.d);
         2'd2: f = work_ff.b ^ work_ff.c ^ work_ff.d;
         default: f = work_ff.c ^ (work_ff.b | ~work_ff.d);
      endcase
      kk  = md5_pkg::K_TABLE[ctrl.idx];
      s   = md5_pkg::ROT_TABLE[{ctrl.idx[5:4], ctrl.idx[1:0]}];
      t   = work_ff.a + f + kk + word;
      rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
      work_in = work_ff;
      if (ctrl.start) begin
         work_in = chain;
      end else if (ctrl.step) begin
         work_in.a = work_ff.d;
         work_in.d = work_ff.c;
         work_in.c = work_ff.b;
         work_in.b = work_ff.b + rot;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign sum.a = chain.a + work_ff.a;
   assign sum.b = chain.b + work_ff.b;
   assign sum.c = chain.c + work_ff.c;
   assign sum.d = chain.d + work_ff.d;
endmodule

@@ hw/rtl/md5_merge.sv @@
module md5_merge #(
   parameter int unsigned ACT = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  md5_pkg::abcd_type     digests [ACT],
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [127:0]          rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  busy
);
   localparam int unsigned CW = (ACT > 1) ? $clog2(ACT) : 1;
   md5_pkg::abcd_type hold_ff [ACT];
   logic [CW-1:0] sel_ff, sel_in;
   logic          valid_ff, valid_in;
   md5_pkg::abcd_type cur;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         sel_in   = '0;
         valid_in = 1'b1;
      end else if (valid_ff && rsp_tready) begin
         if (32'(sel_ff) == ACT - 1) begin
            valid_in = 1'b0;
         end else begin
            sel_in = sel_ff + 1'b1;
         end
      end
      cur = hold_ff[sel_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         hold_ff <= digests;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {md5_pkg::bswap(cur.c), md5_pkg::bswap(cur.d),
                        md5_pkg::bswap(cur.a), md5_pkg::bswap(cur.b)};
   assign rsp_tuser  = 2'(sel_ff);
   assign rsp_tlast  = (32'(sel_ff) == ACT - 1);
   assign busy       = valid_ff;
endmodule

@@ hw/rtl/md5_four_lane_hash.sv @@
// MD5 digests for up to four messages processed side by side.
// Request channel req_*: one padded little-endian word per lane in tdata,
// tlast set on word sixteen of the final block ends all messages; tlast on
// any other word is ignored.
// Words 1..15 of a block are taken one per cycle. Word sixteen starts the
// compression, one MD5 step a cycle in every lane's round unit; no words
// are taken while it runs or while the sums are folded.
// After a final block the merge stage holds all digests and presents them
// on rsp_* in lane order, tuser the lane, tlast on the last lane. Digest
// words are byte-swapped: tdata[63:0] = A:B, tdata[127:64] = C:D.
// A stalled response channel holds the current digest; new requests are
// taken meanwhile and block only when another set of digests would need
// the holding registers.
// Reset (synchronous, active high) returns the chaining values to the MD5
// initial constants, the word position to zero and drops pending digests.
`include "md5_four_lane_hash_macros.svh"
module md5_four_lane_hash #(
   parameter int unsigned LANES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // word_lane3, word_lane2, word_lane1, word_lane0
   input  logic         req_tlast,  // message_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // digest_high, digest_low
   output logic [1:0]   rsp_tuser,  // lane_number
   output logic         rsp_tlast   // final_lane
);
   localparam int unsigned ACT = (LANES < md5_pkg::IN_LANES) ? LANES : md5_pkg::IN_LANES;

   logic [31:0]       words_ff [16][ACT];
   md5_pkg::abcd_type chain_ff [ACT];
   md5_pkg::abcd_type sums [ACT];
   md5_pkg::state_type state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [5:0]  step_ff, step_in;
   logic        last_ff, last_in;
   logic        busy, load;
   md5_pkg::ctrl_type ctrl;
   logic [3:0]  g;
   logic        accept;

   assign accept = req_tvalid && req_tready;
   assign g      = md5_pkg::word_index(step_ff);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      req_tready   = 1'b0;
      load         = 1'b0;
      ctrl         = '0;
      ctrl.idx     = step_ff;
      unique case (state_ff)
         md5_pkg::ST_LOAD: begin
            req_tready = !(pos_ff == 4'd15 && busy && req_tlast);
            if (accept) begin
               pos_in = pos_ff + 4'd1;
               if (pos_ff == 4'd15) begin
                  state_in   = md5_pkg::ST_RUN;
                  last_in    = req_tlast;
                  step_in    = '0;
                  ctrl.start = 1'b1;
               end
            end
         end
         md5_pkg::ST_RUN: begin
            ctrl.step = 1'b1;
            step_in   = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = md5_pkg::ST_EMIT;
            end
         end
         default: begin
            ctrl.fold    = 1'b1;
            ctrl.restart = last_ff;
            load         = last_ff;
            state_in     = md5_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_LOAD;
         pos_ff   <= '0;
         step_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         step_ff  <= step_in;
         last_ff  <= last_in;
      end
      if (accept) begin
         for (int l = 0; l < ACT; l++) begin
            words_ff[pos_ff][l] <= req_tdata[32*l +: 32];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < ACT; l++) begin
         if (reset || (ctrl.fold && ctrl.restart)) begin
            chain_ff[l] <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
         end else if (ctrl.fold) begin
            chain_ff[l] <= sums[l];
         end
      end
   end

   for (genvar l = 0; l < ACT; l++) begin : g_lane
      md5_lane u_lane (
         .clock (clock),
         .ctrl  (ctrl),
         .word  ((ctrl.start) ? 32'd0 : words_ff[g][l]),
         .chain (chain_ff[l]),
         .sum   (sums[l])
      );
   end

   md5_merge #(.ACT(ACT)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .digests    (sums),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .busy       (busy)
   );

   `MD5_ASSERT_IMPL(a_no_req_in_run, clock, reset, state_ff == md5_pkg::ST_RUN, !req_tready)
   `MD5_ASSERT_NEXT(a_emit_back, clock, reset, state_ff == md5_pkg::ST_EMIT,
                    state_ff == md5_pkg::ST_LOAD && pos_ff == 4'd0)
   `MD5_ASSERT_NEXT(a_load_valid, clock, reset, load, rsp_tvalid && rsp_tuser == 2'd0)
endmodule

@@ sim/md5_four_lane_hash_checker.sv @@
module md5_four_lane_hash_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           digests_pending,
   output int           digests_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]   lane;
      logic [127:0] digest;
      logic         last_lane;
   } digest_type;

   localparam int unsigned ACTIVE_LANES = 4;

   logic [31:0] chain [4][4];
   logic [31:0] block [16][4];
   logic [3:0]  word_pos;
   digest_type  digest_queue [$];

   assign digests_pending = digest_queue.size();

   task automatic report(input string what);
      $display("%0t ns: digest mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic load_initial();
      for (int l = 0; l < 4; l++) begin
         chain[l][0] = md5_pkg::IV_A;
         chain[l][1] = md5_pkg::IV_B;
         chain[l][2] = md5_pkg::IV_C;
         chain[l][3] = md5_pkg::IV_D;
      end
   endtask

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   task automatic compress_lane(input int l);
      logic [31:0] a, b, c, d, f, t;
      int g, s;
      a = chain[l][0]; b = chain[l][1]; c = chain[l][2]; d = chain[l][3];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            f = (b & c) | (~b & d); g = i;
         end else if (i < 32) begin
            f = (b & d) | (c & ~d); g = (5 * i + 1) % 16;
         end else if (i < 48) begin
            f = b ^ c ^ d; g = (3 * i + 5) % 16;
         end else begin
            f = c ^ (b | ~d); g = (7 * i) % 16;
         end
         t = a + f + md5_pkg::K_TABLE[i] + block[g][l];
         s = md5_pkg::ROT_TABLE[((i / 16) * 4) + (i % 4)];
         a = d; d = c; c = b;
         b = b + ((t << s) | (t >> (32 - s)));
      end
      chain[l][0] += a; chain[l][1] += b; chain[l][2] += c; chain[l][3] += d;
   endtask

   task automatic take_words(input logic [127:0] words, input logic ends);
      digest_type e;
      for (int l = 0; l < 4; l++) block[word_pos][l] = words[32*l +: 32];
      if (word_pos == 4'd15) begin
         for (int l = 0; l < ACTIVE_LANES; l++) compress_lane(l);
         if (ends) begin
            for (int l = 0; l < ACTIVE_LANES; l++) begin
               e.lane = 2'(l);
               e.digest = {swap_bytes(chain[l][2]), swap_bytes(chain[l][3]),
                           swap_bytes(chain[l][0]), swap_bytes(chain[l][1])};
               e.last_lane = (l == ACTIVE_LANES - 1);
               digest_queue.push_back(e);
            end
            load_initial();
         end
      end
      word_pos++;
   endtask

   initial begin
      fail_count = 0;
      digests_seen = 0;
      word_pos = '0;
      load_initial();
   end

   always @(posedge clock) begin
      digest_type e;
      if (reset) begin
         word_pos = '0;
         load_initial();
         digest_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            digests_seen++;
            if (digest_queue.size() == 0) begin
               report($sformatf("unexpected digest lane %0d", rsp_tuser));
            end else begin
               e = digest_queue.pop_front();
               if (rsp_tuser !== e.lane)
                  report($sformatf("lane %0d, expected %0d", rsp_tuser, e.lane));
               if (rsp_tdata !== e.digest)
                  report($sformatf("lane %0d digest %h, expected %h",
                                   e.lane, rsp_tdata, e.digest));
               if (rsp_tlast !== e.last_lane)
                  report($sformatf("lane %0d tlast %b, expected %b",
                                   e.lane, rsp_tlast, e.last_lane));
            end
         end
         if (req_tvalid && req_tready) take_words(req_tdata, req_tlast);
      end
   end
endmodule

@@ sim/tb_md5_four_lane_hash.sv @@
module tb_md5_four_lane_hash;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   int           fail_count, digests_pending, digests_seen;
   int           send_idle = 0, recv_stall = 0, hold_off = 0;
   int           cycles = 0, requests = 0, messages = 0;

   md5_four_lane_hash i_dut (.*);
   md5_four_lane_hash_checker i_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stall, long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send(input logic [127:0] words, input logic ends);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= words;
      req_tlast  <= ends;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests++;
      @(negedge clock);
   endtask

   function automatic logic [127:0] rand_words();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // a message of n blocks; stray last flags on early words are ignored
   task automatic send_message(input int n, input int mode);
      logic [127:0] w;
      for (int b = 0; b < n; b++)
         for (int i = 0; i < 16; i++) begin
            case (mode)
               0: w = rand_words();
               1: w = '0;
               2: w = '1;
               default: w = {4{32'h8000_0001 << (i % 32)}} ^ rand_words() & {4{32'hFF00}};
            endcase
            send(w, (b == n - 1 && i == 15) ? 1'b1 : ($urandom_range(7) == 0));
         end
      messages++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (digests_pending > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, ones, patterned, a block without end then end
      send_message(1, 1);
      send_message(1, 2);
      send_message(1, 3);
      // block with no end flag anywhere, then closing block
      for (int i = 0; i < 16; i++) send(rand_words(), 1'b0);
      send_message(1, 0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 88; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 88; end
            default: begin send_idle = 21; recv_stall = 21; end
         endcase
         if (phase == 0) hold_off = 600;
         for (int m = 0; m < 4; m++) send_message(1, 0);
         drain();
      end
      drain();
      $display("%0d requests in %0d messages, %0d digests checked over four idling phases",
               requests, messages, digests_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

@@ md5_four_lane_hash.f @@
+incdir+hw/rtl
hw/rtl/md5_pkg.sv
hw/rtl/md5_lane.sv
hw/rtl/md5_merge.sv
hw/rtl/md5_four_lane_hash.sv
sim/md5_four_lane_hash_checker.sv
sim/tb_md5_four_lane_hash.sv
